// ===== rtl/core/vra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the vector rotation angle block: default sizes, fixed-point
// widths, the CORDIC arctangent table and the flag bundle of the pipeline.
// No dependencies.

package vra_pkg;

	localparam int COORD_WIDTH_DEF  = 16;
	localparam int ANGLE_WIDTH_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// The larger of the two magnitudes enters the CORDIC with its top bit at 29.
	localparam int NORM_BITS = 30;
	// CORDIC x/y hold up to about 2.4 * 2^30 with sign; z stays below 2^31 in size.
	localparam int CORDIC_XW = 34;
	localparam int CORDIC_ZW = 34;

	// atan(2^-i) in units of 2^-32 turn, rounded to nearest.
	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// Quadrant and special-case flags that ride along with each word.
	typedef struct packed {
		logic deg;    // either vector is zero
		logic sn;     // sine negative
		logic cn;     // cosine negative
		logic czero;  // cosine zero
		logic szero;  // sine zero
	} meta_t;

endpackage

`default_nettype wire

// ===== rtl/core/vector_rotation_angle.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Vector rotation angle: counter-clockwise angle from a start vector to a
// destination vector, by cross/dot product and a pipelined CORDIC.
// Depends on vra_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one word of two signed
//   vectors; the output channel (out_valid/out_ready) returns one word per
//   input: the angle as a fraction of a full turn (2^ANGLE_WIDTH per turn)
//   and a degenerate flag, set with angle 0 when either vector is zero.
//   A new word can be taken every cycle while the receiver does not stall.
//   The pipeline has CORDIC_STEPS + clog2(max(2*COORD_WIDTH, 30)) + 5
//   register stages (26 with the default sizes): products, sums, magnitudes,
//   one stage per bit of the normalizing shift, one per CORDIC iteration,
//   rounding, and quadrant placement.
//   When the receiver stalls, the whole pipeline holds; a one-word skid
//   register on the input still takes the word offered in that cycle, and
//   in_ready then drops until the pipeline moves again.
//   Reset empties the pipeline and the skid register; there is no other
//   state and no configuration.

module vector_rotation_angle #(
	parameter int COORD_WIDTH  = vra_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH  = vra_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STEPS = vra_pkg::CORDIC_STEPS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire signed [COORD_WIDTH-1:0] start_x,
	input  wire signed [COORD_WIDTH-1:0] start_y,
	input  wire signed [COORD_WIDTH-1:0] dest_x,
	input  wire signed [COORD_WIDTH-1:0] dest_y,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [ANGLE_WIDTH-1:0]       angle,
	output logic                         degenerate
);

	localparam int CW      = COORD_WIDTH;
	localparam int AW      = ANGLE_WIDTH;
	localparam int CS      = CORDIC_STEPS;
	localparam int PW      = 2 * CW;
	localparam int SW      = PW + 1;
	localparam int NB      = vra_pkg::NORM_BITS;
	localparam int NW      = (PW > NB) ? PW : NB;
	localparam int NL      = $clog2(NW);
	localparam int XW      = vra_pkg::CORDIC_XW;
	localparam int ZW      = vra_pkg::CORDIC_ZW;
	localparam int ST_RND  = 4 + NL + CS;
	localparam int NS      = ST_RND + 1;
	localparam int RSH     = 32 - AW;

	localparam logic [32:0]   RND_HALF = (RSH == 0) ? 33'd0 : (33'd1 << (RSH - 1));
	localparam logic [AW-1:0] QUARTER  = AW'(1) << (AW - 2);
	localparam logic [AW-1:0] HALF     = AW'(1) << (AW - 1);
	localparam logic [AW-1:0] THREE_Q  = QUARTER | HALF;

	// ---------------------------------------------------------------- control
	logic          en;
	logic          skid_full_q;
	logic          src_valid;
	logic [NS:1]   vld;
	logic [NS:0]   vchain;

	logic signed [CW-1:0] skid_sx_q, skid_sy_q, skid_dx_q, skid_dy_q;
	logic signed [CW-1:0] src_sx, src_sy, src_dx, src_dy;

	assign en        = !vld[NS] || out_ready;
	assign in_ready  = !skid_full_q;
	assign out_valid = vld[NS];
	assign src_valid = skid_full_q || in_valid;
	assign vchain    = {vld, src_valid};

	always_comb begin
		if (skid_full_q) begin
			src_sx = skid_sx_q;
			src_sy = skid_sy_q;
			src_dx = skid_dx_q;
			src_dy = skid_dy_q;
		end else begin
			src_sx = start_x;
			src_sy = start_y;
			src_dx = dest_x;
			src_dy = dest_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
			vld         <= '0;
		end else begin
			if (en) begin
				skid_full_q <= 1'b0;
				vld         <= vchain[NS-1:0];
			end else if (in_valid && !skid_full_q) begin
				skid_full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_sx_q <= start_x;
			skid_sy_q <= start_y;
			skid_dx_q <= dest_x;
			skid_dy_q <= dest_y;
		end
	end

	// ------------------------------------------------- stage 1: four products
	logic signed [PW-1:0] p_sxdy_s1, p_sydx_s1, p_sxdx_s1, p_sydy_s1;
	logic                 deg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_sxdy_s1 <= PW'(src_sx) * PW'(src_dy);
			p_sydx_s1 <= PW'(src_sy) * PW'(src_dx);
			p_sxdx_s1 <= PW'(src_sx) * PW'(src_dx);
			p_sydy_s1 <= PW'(src_sy) * PW'(src_dy);
			deg_s1    <= (src_sx == '0 && src_sy == '0) || (src_dx == '0 && src_dy == '0);
		end
	end

	// ----------------------------------------- stage 2: cross and dot product
	logic signed [SW-1:0] sin_s2, cos_s2;
	logic                 deg_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s2 <= SW'(p_sxdy_s1) - SW'(p_sydx_s1);
			cos_s2 <= SW'(p_sxdx_s1) + SW'(p_sydy_s1);
			deg_s2 <= deg_s1;
		end
	end

	// ----------------------------------------- stage 3: magnitudes and flags
	logic [SW-1:0]  sin_abs, cos_abs;
	logic [NW-1:0]  mag_c_s3, mag_s_s3;
	vra_pkg::meta_t meta_s [3:NS-1];

	always_comb begin
		sin_abs = sin_s2[SW-1] ? -sin_s2 : sin_s2;
		cos_abs = cos_s2[SW-1] ? -cos_s2 : cos_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_c_s3         <= NW'(cos_abs[PW-1:0]);
			mag_s_s3         <= NW'(sin_abs[PW-1:0]);
			meta_s[3].deg    <= deg_s2;
			meta_s[3].sn     <= sin_s2[SW-1];
			meta_s[3].cn     <= cos_s2[SW-1];
			meta_s[3].czero  <= (cos_s2 == '0);
			meta_s[3].szero  <= (sin_s2 == '0);
			for (int k = 4; k < NS; k++) begin
				meta_s[k] <= meta_s[k-1];
			end
		end
	end

	// --------------------------- normalizing shift, one power of two a stage
	// Both magnitudes move left together until the larger has its top bit at
	// NW-1; its top NB bits then equal the truncating shift into [2^29, 2^30).
	logic [NW-1:0] nrm_c_s [1:NL];
	logic [NW-1:0] nrm_s_s [1:NL];
	logic [NW-1:0] nrm_c_d [1:NL];
	logic [NW-1:0] nrm_s_d [1:NL];

	always_comb begin
		logic [NW-1:0] cv, sv;
		int            sh;
		for (int j = 0; j < NL; j++) begin
			if (j == 0) begin
				cv = mag_c_s3;
				sv = mag_s_s3;
			end else begin
				cv = nrm_c_s[j];
				sv = nrm_s_s[j];
			end
			sh = 1 << (NL - 1 - j);
			if (((cv | sv) >> (NW - sh)) == '0) begin
				nrm_c_d[j+1] = cv << sh;
				nrm_s_d[j+1] = sv << sh;
			end else begin
				nrm_c_d[j+1] = cv;
				nrm_s_d[j+1] = sv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 1; j <= NL; j++) begin
				nrm_c_s[j] <= nrm_c_d[j];
				nrm_s_s[j] <= nrm_s_d[j];
			end
		end
	end

	// ------------------------------ CORDIC vectoring, one iteration a stage
	logic signed [XW-1:0] cx_s [1:CS];
	logic signed [XW-1:0] cy_s [1:CS];
	logic signed [ZW-1:0] cz_s [1:CS];
	logic signed [XW-1:0] cx_d [1:CS];
	logic signed [XW-1:0] cy_d [1:CS];
	logic signed [ZW-1:0] cz_d [1:CS];

	always_comb begin
		logic signed [XW-1:0] xi, yi, xs, ys;
		logic signed [ZW-1:0] zi, at;
		for (int i = 0; i < CS; i++) begin
			if (i == 0) begin
				xi = {{(XW-NB){1'b0}}, nrm_c_s[NL][NW-1 -: NB]};
				yi = {{(XW-NB){1'b0}}, nrm_s_s[NL][NW-1 -: NB]};
				zi = '0;
			end else begin
				xi = cx_s[i];
				yi = cy_s[i];
				zi = cz_s[i];
			end
			xs = xi >>> i;
			ys = yi >>> i;
			at = {{(ZW-32){1'b0}}, vra_pkg::ATAN_TURNS[i]};
			if (!yi[XW-1]) begin
				cx_d[i+1] = xi + ys;
				cy_d[i+1] = yi - xs;
				cz_d[i+1] = zi + at;
			end else begin
				cx_d[i+1] = xi - ys;
				cy_d[i+1] = yi + xs;
				cz_d[i+1] = zi - at;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 1; i <= CS; i++) begin
				cx_s[i] <= cx_d[i];
				cy_s[i] <= cy_d[i];
				cz_s[i] <= cz_d[i];
			end
		end
	end

	// ----------------------- clamp at zero and round to the output angle width
	logic [31:0]   a_clamp;
	logic [32:0]   a_sum;
	logic [AW-1:0] a_rnd_s;

	always_comb begin
		a_clamp = cz_s[CS][ZW-1] ? 32'd0 : cz_s[CS][31:0];
		a_sum   = {1'b0, a_clamp} + RND_HALF;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_rnd_s <= a_sum[RSH +: AW];
		end
	end

	// ------------------------------------------ quadrant placement and output
	vra_pkg::meta_t m_last;
	logic [AW-1:0]  a_eff;
	logic [AW-1:0]  ang_d;

	assign m_last = meta_s[NS-1];

	always_comb begin
		a_eff = m_last.szero ? '0 : a_rnd_s;
		if (m_last.deg) begin
			ang_d = '0;
		end else if (m_last.czero) begin
			ang_d = (!m_last.szero && !m_last.sn) ? QUARTER : THREE_Q;
		end else if (!m_last.sn) begin
			ang_d = m_last.cn ? HALF - a_eff : a_eff;
		end else begin
			// Full turn minus a wraps modulo the angle width.
			ang_d = m_last.cn ? HALF + a_eff : -a_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle      <= ang_d;
			degenerate <= m_last.deg;
		end
	end

	// ------------------------------------------------------------- assertions
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> angle == '0)
		else $error("degenerate word with nonzero angle");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld))
		else $error("pipeline valid bits moved during a stall");

	a_skid_catch: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !en |=> skid_full_q && !in_ready)
		else $error("word accepted during a stall was not held in the skid register");

	a_right_angle: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld[NS-1] && !m_last.deg && m_last.czero
		|=> (angle == QUARTER) || (angle == THREE_Q))
		else $error("zero cosine did not give a quarter or three-quarter turn");

endmodule

`default_nettype wire

// ===== tb/vra_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the vector rotation angle testbench: word types, the angle
// predictor with its own arctangent table, and the queue of expected words.
// Depends on vra_pkg for the default sizes.

package vra_tb_pkg;

	localparam int CW    = vra_pkg::COORD_WIDTH_DEF;
	localparam int AW    = vra_pkg::ANGLE_WIDTH_DEF;
	localparam int STEPS = vra_pkg::CORDIC_STEPS_DEF;

	localparam longint unsigned QUARTER = 64'd1 << (AW - 2);
	localparam longint unsigned HALF    = QUARTER << 1;
	localparam longint unsigned FULL    = HALF << 1;

	// atan(2^-i) in units of 2^-32 turn.
	localparam longint ATAN_TURN_UNITS [32] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
		64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
		64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
		64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
	};

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic [AW-1:0] angle;
		logic          degenerate;
	} angle_word_t;

	class rotation_checker;
		angle_word_t pending[$];
		int unsigned words_in;
		int unsigned words_out;
		int unsigned flagged;
		int unsigned mismatches;

		function angle_word_t rotation_of(coord_t sx, coord_t sy, coord_t dx, coord_t dy);
			longint sine, cosine, x, y, z, xs, ys, a, turn;
			longint unsigned sm, cm, big;
			angle_word_t r;
			r.degenerate = 1'b0;
			if ((sx == 0 && sy == 0) || (dx == 0 && dy == 0)) begin
				r.angle = '0;
				r.degenerate = 1'b1;
				return r;
			end
			sine   = longint'(sx) * longint'(dy) - longint'(sy) * longint'(dx);
			cosine = longint'(sx) * longint'(dx) + longint'(sy) * longint'(dy);
			sm = (sine < 0) ? -sine : sine;
			cm = (cosine < 0) ? -cosine : cosine;
			if (cm == 0) begin
				turn = (sine > 0) ? QUARTER : 3 * QUARTER;
			end else begin
				a = 0;
				if (sm != 0) begin
					// Both magnitudes move together until the larger sits in [2^29, 2^30).
					big = (cm > sm) ? cm : sm;
					while (big >= (64'd1 << 30)) begin
						big >>= 1;
						cm >>= 1;
						sm >>= 1;
					end
					while (big < (64'd1 << 29)) begin
						big <<= 1;
						cm <<= 1;
						sm <<= 1;
					end
					x = cm;
					y = sm;
					z = 0;
					for (int i = 0; i < STEPS && i < 32; i++) begin
						xs = x >>> i;
						ys = y >>> i;
						if (y >= 0) begin
							x = x + ys;
							y = y - xs;
							z = z + ATAN_TURN_UNITS[i];
						end else begin
							x = x - ys;
							y = y + xs;
							z = z - ATAN_TURN_UNITS[i];
						end
					end
					if (z < 0)
						z = 0;
					if (AW < 32)
						a = (z + (64'sd1 << (31 - AW))) >>> (32 - AW);
					else
						a = z;
				end
				if (sine >= 0)
					turn = (cosine < 0) ? HALF - a : a;
				else
					turn = (cosine < 0) ? HALF + a : FULL - a;
			end
			r.angle = turn[AW-1:0];
			return r;
		endfunction

		function void note_word(coord_t sx, coord_t sy, coord_t dx, coord_t dy);
			pending.push_back(rotation_of(sx, sy, dx, dy));
			words_in++;
		endfunction

		task report(string what);
			mismatches++;
			$display("MISMATCH at %0t: %s", $time, what);
		endtask

		task check_word(logic [AW-1:0] angle, logic degenerate);
			angle_word_t want;
			words_out++;
			if (pending.size() == 0) begin
				report($sformatf("output word %0d arrived with nothing outstanding", words_out));
				return;
			end
			want = pending.pop_front();
			if (angle !== want.angle)
				report($sformatf("word %0d angle %h, expected %h",
					words_out, angle, want.angle));
			if (degenerate !== want.degenerate)
				report($sformatf("word %0d degenerate %b, expected %b",
					words_out, degenerate, want.degenerate));
			if (want.degenerate)
				flagged++;
		endtask
	endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the vector rotation angle testbench: clock, reset, input driver
// and output sink around u_top, with directed and random vector pairs.
// Depends on vra_pkg, vra_tb_pkg and the vector_rotation_angle RTL.

module testbench;

	typedef vra_tb_pkg::coord_t coord_t;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_WORDS = 1600;
	localparam coord_t C_MIN = 16'sh8000;
	localparam coord_t C_MAX = 16'sh7FFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	coord_t start_x = '0;
	coord_t start_y = '0;
	coord_t dest_x = '0;
	coord_t dest_y = '0;
	wire in_ready;
	wire out_valid;
	wire [vra_tb_pkg::AW-1:0] angle;
	wire degenerate;

	int send_pct = 0;
	int recv_pct = 0;
	int unsigned cycles = 0;
	vra_tb_pkg::rotation_checker sb;

	vector_rotation_angle u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_x(start_x),
		.start_y(start_y),
		.dest_x(dest_x),
		.dest_y(dest_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.angle(angle),
		.degenerate(degenerate)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int idle_len(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic coord_t extreme_coord();
		case ($urandom_range(0, 4))
			0: return C_MIN;
			1: return C_MAX;
			2: return -1;
			3: return 1;
			default: return 0;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(coord_t sx, coord_t sy, coord_t dx, coord_t dy);
		int gap;
		gap = idle_len(send_pct);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) begin
				start_x = coord_t'($urandom);
				start_y = coord_t'($urandom);
				dest_x = coord_t'($urandom);
				dest_y = coord_t'($urandom);
				@(negedge clk);
			end
		end
		in_valid = 1'b1;
		start_x = sx;
		start_y = sy;
		dest_x = dx;
		dest_y = dy;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_word(sx, sy, dx, dy);
		@(negedge clk);
	endtask

	task automatic send_random_pair();
		int kind, k;
		coord_t sx, sy, dx, dy;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			sx = coord_t'($urandom);
			sy = coord_t'($urandom);
			dx = coord_t'($urandom);
			dy = coord_t'($urandom);
		end else if (kind < 72) begin
			sx = coord_t'(int'($urandom_range(0, 8)) - 4);
			sy = coord_t'(int'($urandom_range(0, 8)) - 4);
			dx = coord_t'(int'($urandom_range(0, 8)) - 4);
			dy = coord_t'(int'($urandom_range(0, 8)) - 4);
		end else if (kind < 84) begin
			sx = extreme_coord();
			sy = extreme_coord();
			dx = extreme_coord();
			dy = extreme_coord();
		end else if (kind < 92) begin
			// Parallel or opposite vectors put the sine at zero.
			k = int'($urandom_range(0, 32)) - 16;
			sx = coord_t'(int'($urandom_range(0, 4000)) - 2000);
			sy = coord_t'(int'($urandom_range(0, 4000)) - 2000);
			dx = coord_t'(sx * k);
			dy = coord_t'(sy * k);
		end else begin
			// Perpendicular vectors put the cosine at zero.
			sx = coord_t'($urandom);
			sy = coord_t'($urandom);
			if ($urandom_range(0, 1)) begin
				dx = -sy;
				dy = sx;
			end else begin
				dx = sy;
				dy = -sx;
			end
		end
		send_word(sx, sy, dx, dy);
	endtask

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else begin
				out_ready = 1'b1;
				stall = idle_len(recv_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (arst_n && out_valid && out_ready)
			sb.check_word(angle, degenerate);
		if (cycles > CYCLE_LIMIT) begin
			$display("cycle limit of %0d reached, %0d words still outstanding",
				CYCLE_LIMIT, sb.pending.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Zero vectors, axis cases, each quadrant, the wrap to zero and the extremes.
		send_word(0, 0, 5, 7);
		send_word(3, -2, 0, 0);
		send_word(0, 0, 0, 0);
		send_word(1, 0, 0, 1);
		send_word(1, 0, 0, -1);
		send_word(3, 4, 6, 8);
		send_word(1, 0, -1, 0);
		send_word(2, 1, 1, 2);
		send_word(1, 0, -3, 1);
		send_word(1, 0, -3, -1);
		send_word(1, 0, 3, -1);
		send_word(1, 0, C_MAX, -1);
		send_word(C_MIN, C_MIN, C_MIN, C_MIN);
		send_word(C_MIN, C_MAX, C_MAX, C_MIN);
		send_word(C_MIN, 0, 0, C_MIN);
		send_word(C_MAX, C_MAX, C_MIN, C_MIN);
		send_word(C_MIN, C_MAX, C_MIN, C_MIN);
		send_word(-1, -1, C_MAX, C_MIN);
		send_word(C_MAX, 0, C_MAX, 1);
		send_word(0, C_MAX, 1, C_MIN);
		send_word(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_pct = 0;
					recv_pct = 0;
				end
				1: begin
					send_pct = 30;
					recv_pct = 30;
				end
				2: begin
					send_pct = 60;
					recv_pct = 10;
				end
				default: begin
					send_pct = 10;
					recv_pct = 60;
				end
			endcase
			for (int n = 0; n < RANDOM_WORDS / 4; n++)
				send_random_pair();
		end
		in_valid = 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d vector pairs sent, %0d angles checked, %0d with a zero vector",
			sb.words_in, sb.words_out, sb.flagged);
		$display("summary: %0d mismatches over four stall mixes", sb.mismatches);
		if (sb.mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
